/* src/abr_pkg.sv */
// Shared constants and types of the annulus boundary reflection block.
package abr_pkg;

  localparam int NORM_BITS = 30;
  localparam int GAIN_BITS = 15;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd5;

  localparam int RST_INNER = 76800;
  localparam int RST_OUTER = 128000;
  localparam int RST_GAIN  = 26214;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_OUTER = 2'd1,
    KIND_INNER = 2'd2
  } kind_t;

endpackage

/* src/abr_if.sv */
// Valid/ready channel interfaces for particle items and bounce results.
interface abr_in_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] vel_x;
  logic signed [CW-1:0] vel_y;
  logic signed [CW-1:0] vel_z;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, vel_z, output ready);
endinterface

interface abr_out_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] new_pos_x;
  logic signed [CW-1:0] new_pos_y;
  logic signed [CW-1:0] new_pos_z;
  logic signed [CW-1:0] new_vel_x;
  logic signed [CW-1:0] new_vel_y;
  logic signed [CW-1:0] new_vel_z;
  logic [1:0]           bounce_kind;
  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, bounce_kind, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                new_vel_z, bounce_kind, output ready);
endinterface

/* src/abr_sqrt.sv */
// Pipelined integer floor square root, one result bit per stage.
module abr_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad_sq,
  output logic [RW-1:0]   root
);
  localparam int SW = 2 * RW + 1;

  logic [SW-1:0] op_r  [RW];
  logic [SW-1:0] res_r [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam logic [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} << (2 * (RW - 1 - i));
    logic [SW-1:0] op_in;
    logic [SW-1:0] res_in;
    logic [SW-1:0] trial;
    logic [SW-1:0] op_nxt;
    logic [SW-1:0] res_nxt;

    if (i == 0) begin : g_first
      assign op_in  = SW'(rad_sq);
      assign res_in = '0;
    end else begin : g_next
      assign op_in  = op_r[i-1];
      assign res_in = res_r[i-1];
    end

    always_comb begin
      trial = res_in + ONE;
      if (op_in >= trial) begin
        op_nxt  = op_in - trial;
        res_nxt = (res_in >> 1) + ONE;
      end else begin
        op_nxt  = op_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op_r[i]  <= op_nxt;
        res_r[i] <= res_nxt;
      end
    end
  end

  assign root = res_r[RW-1][RW-1:0];

endmodule

/* src/abr_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
module abr_div #(
  parameter int NUMW  = 63,
  parameter int DEN_W = 33,
  parameter int QW    = 31
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUMW-1:0]  num,
  input  logic [DEN_W-1:0] den,
  output logic [QW-1:0]    quo,
  output logic [DEN_W-1:0] rem,
  output logic [DEN_W-1:0] den_o
);
  localparam int XW = DEN_W + QW;

  logic [XW-1:0]    rem_r [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [QW-1:0]    quo_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int K = QW - 1 - i;
    logic [XW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    quo_in;
    logic [XW-1:0]    trial;
    logic [XW-1:0]    rem_nxt;
    logic [QW-1:0]    quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = XW'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    always_comb begin
      trial   = XW'(den_in) << K;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= trial) begin
        rem_nxt    = rem_in - trial;
        quo_nxt[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_in;
        quo_r[i] <= quo_nxt;
      end
    end
  end

  assign quo   = quo_r[QW-1];
  assign rem   = rem_r[QW-1][DEN_W-1:0];
  assign den_o = den_r[QW-1];

endmodule

/* src/annulus_boundary_reflect_core.sv */
// Top level of the annulus boundary reflection pipeline.
// The block keeps particles inside an annular arena: each transfer on the input channel carries
// one position and velocity, and each produces exactly one result in order. A new item is taken
// in every clock cycle while the pipeline is not held. Each item passes the input stages a to d,
// the RW = COORD_WIDTH + 1 stages of the square root, the QW = max(31, COORD_WIDTH - 1) stages of
// the four parallel dividers that form the unit normal and the projected position, stages g to l
// and the result register. When the result register is full and not taken, the whole pipeline
// holds. Configuration registers are to be written only while no item is in flight.
module annulus_boundary_reflect_core #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  abr_in_if.sink                         in_ch,
  abr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [abr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [COORD_WIDTH-1:0]         cfg_wdata
);
  import abr_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int RW    = CW + 1;
  localparam int NUMW  = (CW + NORM_BITS > 2 * CW - 1) ? CW + NORM_BITS : 2 * CW - 1;
  localparam int QW    = (NORM_BITS + 1 > CW - 1) ? NORM_BITS + 1 : CW - 1;
  localparam int NXW   = NORM_BITS + 2;
  localparam int RLW   = CW + 1;
  localparam int PW    = CW + NXW;
  localparam int PSW   = PW + 1;
  localparam int DW    = PSW + 1 - NORM_BITS;
  localparam int EW    = DW + NXW;
  localparam int VW    = EW + 3 - NORM_BITS;
  localparam int GW    = VW + GAIN_W + 1;
  localparam int SATW  = GW + 1 - GAIN_BITS;
  localparam int HALF_N = 1 << (NORM_BITS - 1);
  localparam int HALF_E = 1 << (NORM_BITS - 2);
  localparam int HALF_G = 1 << (GAIN_BITS - 1);

  typedef struct packed {
    logic                 vld;
    kind_t                kind;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
  } pass_t;

  typedef struct packed {
    pass_t            p;
    logic [CW-2:0]    rad;
    logic             negx;
    logic             negy;
    logic [NUMW-1:0]  nx0;
    logic [NUMW-1:0]  ny0;
    logic [NUMW-1:0]  nx1;
    logic [NUMW-1:0]  ny1;
  } side1_t;

  typedef struct packed {
    pass_t         p;
    logic [CW-2:0] rad;
    logic          negx;
    logic          negy;
    logic          rz;
  } side2_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
  } res_t;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) begin
      sat_cw = {1'b0, {(CW-1){1'b1}}};
    end else if (v < lo) begin
      sat_cw = {1'b1, {(CW-1){1'b0}}};
    end else begin
      sat_cw = v[CW-1:0];
    end
  endfunction

  // Configuration registers.
  logic signed [CW-1:0]   cx_r, cy_r, cz_r;
  logic [CW-2:0]          rin_r, rout_r;
  logic [GAIN_W-1:0]      gain_r;
  logic [2*CW-3:0]        rin_sq_r, rout_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      cz_r   <= '0;
      rin_r  <= (CW-1)'(RST_INNER);
      rout_r <= (CW-1)'(RST_OUTER);
      gain_r <= GAIN_W'(RST_GAIN);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CENTER_X: cx_r   <= $signed(cfg_wdata);
        REG_CENTER_Y: cy_r   <= $signed(cfg_wdata);
        REG_CENTER_Z: cz_r   <= $signed(cfg_wdata);
        REG_INNER:    rin_r  <= cfg_wdata[CW-2:0];
        REG_OUTER:    rout_r <= cfg_wdata[CW-2:0];
        REG_GAIN:     gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rin_sq_r  <= rin_r * rin_r;
    rout_sq_r <= rout_r * rout_r;
  end

  // Global advance: the pipeline moves unless the result register holds an untaken result.
  logic  adv;
  res_t  out_r;
  logic  out_vld_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage a: input register.
  pass_t pa_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= '0;
    end else if (adv) begin
      pa_r <= '{vld: in_ch.valid, kind: KIND_NONE, px: in_ch.pos_x, py: in_ch.pos_y,
                vx: in_ch.vel_x, vy: in_ch.vel_y, vz: in_ch.vel_z};
    end
  end

  // Stage b: offsets from the center.
  pass_t               pb_r;
  logic signed [CW:0]  dx_r, dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r <= '0;
    end else if (adv) begin
      pb_r <= pa_r;
      dx_r <= pa_r.px - cx_r;
      dy_r <= pa_r.py - cy_r;
    end
  end

  // Stage c: magnitudes and squares.
  pass_t           pc_r;
  logic [CW-1:0]   ax_c_r, ay_c_r;
  logic            negx_c_r, negy_c_r;
  logic [2*CW-1:0] sx_r, sy_r;
  logic [CW:0]     ax_full, ay_full;
  logic [CW-1:0]   ax_c, ay_c;

  always_comb begin
    ax_full = dx_r[CW] ? -dx_r : dx_r;
    ay_full = dy_r[CW] ? -dy_r : dy_r;
    ax_c    = ax_full[CW-1:0];
    ay_c    = ay_full[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (adv) begin
      pc_r     <= pb_r;
      ax_c_r   <= ax_c;
      ay_c_r   <= ay_c;
      negx_c_r <= dx_r[CW];
      negy_c_r <= dy_r[CW];
      sx_r     <= ax_c * ax_c;
      sy_r     <= ay_c * ay_c;
    end
  end

  // Stage d: squared radius and wall test.
  pass_t         pd_r;
  pass_t         pd_nxt;
  logic [2*CW:0] r2_r;
  logic [CW-2:0] rad_r;
  logic [CW-1:0] ax_d_r, ay_d_r;
  logic          negx_d_r, negy_d_r;
  logic [2*CW:0] r2_c;
  kind_t         kind_c;
  logic [CW-2:0] rad_c;

  always_comb begin
    r2_c = (2*CW+1)'(sx_r) + (2*CW+1)'(sy_r);
    if (r2_c > (2*CW+1)'(rout_sq_r)) begin
      kind_c = KIND_OUTER;
      rad_c  = rout_r;
    end else if (r2_c < (2*CW+1)'(rin_sq_r)) begin
      kind_c = KIND_INNER;
      rad_c  = rin_r;
    end else begin
      kind_c = KIND_NONE;
      rad_c  = '0;
    end
    pd_nxt      = pc_r;
    pd_nxt.kind = kind_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r <= '0;
    end else if (adv) begin
      pd_r      <= pd_nxt;
      r2_r      <= r2_c;
      rad_r     <= rad_c;
      ax_d_r    <= ax_c_r;
      ay_d_r    <= ay_c_r;
      negx_d_r  <= negx_c_r;
      negy_d_r  <= negy_c_r;
    end
  end

  // Square root and the side line that travels with it.
  side1_t        s1_nxt;
  side1_t        s1_r [RW];
  logic [RW-1:0] root;

  always_comb begin
    s1_nxt.p    = pd_r;
    s1_nxt.rad  = rad_r;
    s1_nxt.negx = negx_d_r;
    s1_nxt.negy = negy_d_r;
    s1_nxt.nx0  = NUMW'(ax_d_r) << NORM_BITS;
    s1_nxt.ny0  = NUMW'(ay_d_r) << NORM_BITS;
    s1_nxt.nx1  = ax_d_r * rad_r;
    s1_nxt.ny1  = ay_d_r * rad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RW; i++) s1_r[i] <= '0;
    end else if (adv) begin
      s1_r[0] <= s1_nxt;
      for (int i = 1; i < RW; i++) s1_r[i] <= s1_r[i-1];
    end
  end

  abr_sqrt #(.RW(RW)) u_sqrt (
    .clk    (clk),
    .en     (adv),
    .rad_sq ((2*RW)'(r2_r)),
    .root   (root)
  );

  // Dividers and their side line.
  side2_t        s2_nxt;
  side2_t        s2_r [QW];
  logic [QW-1:0] q_nx, q_ny, q_rx, q_ry;
  logic [RW-1:0] m_nx, m_ny, m_rx, m_ry;
  logic [RW-1:0] den_q;

  always_comb begin
    s2_nxt.p    = s1_r[RW-1].p;
    s2_nxt.rad  = s1_r[RW-1].rad;
    s2_nxt.negx = s1_r[RW-1].negx;
    s2_nxt.negy = s1_r[RW-1].negy;
    s2_nxt.rz   = (root == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) s2_r[i] <= '0;
    end else if (adv) begin
      s2_r[0] <= s2_nxt;
      for (int i = 1; i < QW; i++) s2_r[i] <= s2_r[i-1];
    end
  end

  abr_div #(.NUMW(NUMW), .DEN_W(RW), .QW(QW)) u_div_nx (
    .clk(clk), .en(adv), .num(s1_r[RW-1].nx0), .den(root),
    .quo(q_nx), .rem(m_nx), .den_o(den_q)
  );
  abr_div #(.NUMW(NUMW), .DEN_W(RW), .QW(QW)) u_div_ny (
    .clk(clk), .en(adv), .num(s1_r[RW-1].ny0), .den(root),
    .quo(q_ny), .rem(m_ny), .den_o()
  );
  abr_div #(.NUMW(NUMW), .DEN_W(RW), .QW(QW)) u_div_rx (
    .clk(clk), .en(adv), .num(s1_r[RW-1].nx1), .den(root),
    .quo(q_rx), .rem(m_rx), .den_o()
  );
  abr_div #(.NUMW(NUMW), .DEN_W(RW), .QW(QW)) u_div_ry (
    .clk(clk), .en(adv), .num(s1_r[RW-1].ny1), .den(root),
    .quo(q_ry), .rem(m_ry), .den_o()
  );

  // Stage g: rounded, signed normal and projected offset.
  pass_t                 pg_r;
  logic signed [NXW-1:0] nx_g_r, ny_g_r;
  logic signed [RLW-1:0] rx_g_r, ry_g_r;
  logic [QW:0]           qr_nx, qr_ny, qr_rx, qr_ry;
  logic signed [QW+1:0]  sn_nx, sn_ny, sn_rx, sn_ry;
  side2_t                s2_t;

  always_comb begin
    s2_t  = s2_r[QW-1];
    qr_nx = (QW+1)'(q_nx) + (QW+1)'({m_nx, 1'b0} >= {1'b0, den_q});
    qr_ny = (QW+1)'(q_ny) + (QW+1)'({m_ny, 1'b0} >= {1'b0, den_q});
    qr_rx = (QW+1)'(q_rx) + (QW+1)'({m_rx, 1'b0} >= {1'b0, den_q});
    qr_ry = (QW+1)'(q_ry) + (QW+1)'({m_ry, 1'b0} >= {1'b0, den_q});
    sn_nx = s2_t.negx ? -$signed({1'b0, qr_nx}) : $signed({1'b0, qr_nx});
    sn_ny = s2_t.negy ? -$signed({1'b0, qr_ny}) : $signed({1'b0, qr_ny});
    sn_rx = s2_t.negx ? -$signed({1'b0, qr_rx}) : $signed({1'b0, qr_rx});
    sn_ry = s2_t.negy ? -$signed({1'b0, qr_ry}) : $signed({1'b0, qr_ry});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_r <= '0;
    end else if (adv) begin
      pg_r <= s2_t.p;
      if (s2_t.rz) begin
        nx_g_r <= NXW'(HALF_N) <<< 1;
        ny_g_r <= '0;
        rx_g_r <= $signed(RLW'(s2_t.rad));
        ry_g_r <= '0;
      end else begin
        nx_g_r <= sn_nx[NXW-1:0];
        ny_g_r <= sn_ny[NXW-1:0];
        rx_g_r <= sn_rx[RLW-1:0];
        ry_g_r <= sn_ry[RLW-1:0];
      end
    end
  end

  // Stage h: velocity dot normal products and the corrected position.
  pass_t                 ph_r;
  logic signed [PW-1:0]  pxm_r, pym_r;
  logic signed [NXW-1:0] nx_h_r, ny_h_r;
  logic signed [CW-1:0]  npx_h_r, npy_h_r;
  logic signed [SATW-1:0] npx_sum, npy_sum;

  always_comb begin
    npx_sum = cx_r + rx_g_r;
    npy_sum = cy_r + ry_g_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
    end else if (adv) begin
      ph_r    <= pg_r;
      pxm_r   <= pg_r.vx * nx_g_r;
      pym_r   <= pg_r.vy * ny_g_r;
      nx_h_r  <= nx_g_r;
      ny_h_r  <= ny_g_r;
      npx_h_r <= sat_cw(npx_sum);
      npy_h_r <= sat_cw(npy_sum);
    end
  end

  // Stage i: rounded normal component of the velocity.
  pass_t                 pi_r;
  logic signed [DW-1:0]  d_r;
  logic signed [NXW-1:0] nx_i_r, ny_i_r;
  logic signed [CW-1:0]  npx_i_r, npy_i_r;
  logic signed [PSW-1:0] dot_sum;
  logic signed [PSW:0]   dot_bias, dot_rnd;

  always_comb begin
    dot_sum  = pxm_r + pym_r;
    dot_bias = dot_sum[PSW-1] ? (PSW+1)'(HALF_N - 1) : (PSW+1)'(HALF_N);
    dot_rnd  = dot_sum + dot_bias;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pi_r <= '0;
    end else if (adv) begin
      pi_r    <= ph_r;
      d_r     <= $signed(dot_rnd[PSW:NORM_BITS]);
      nx_i_r  <= nx_h_r;
      ny_i_r  <= ny_h_r;
      npx_i_r <= npx_h_r;
      npy_i_r <= npy_h_r;
    end
  end

  // Stage j: normal component times the normal.
  pass_t                pj_r;
  logic signed [EW-1:0] ex_r, ey_r;
  logic signed [CW-1:0] npx_j_r, npy_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pj_r <= '0;
    end else if (adv) begin
      pj_r    <= pi_r;
      ex_r    <= d_r * nx_i_r;
      ey_r    <= d_r * ny_i_r;
      npx_j_r <= npx_i_r;
      npy_j_r <= npy_i_r;
    end
  end

  // Stage k: reflected planar velocity.
  pass_t                pk_r;
  logic signed [VW-1:0] vpx_r, vpy_r;
  logic signed [CW-1:0] npx_k_r, npy_k_r;
  logic signed [EW:0]   ex_bias, ey_bias, ex_rnd, ey_rnd;

  always_comb begin
    ex_bias = ex_r[EW-1] ? (EW+1)'(HALF_E - 1) : (EW+1)'(HALF_E);
    ey_bias = ey_r[EW-1] ? (EW+1)'(HALF_E - 1) : (EW+1)'(HALF_E);
    ex_rnd  = ex_r + ex_bias;
    ey_rnd  = ey_r + ey_bias;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pk_r <= '0;
    end else if (adv) begin
      pk_r    <= pj_r;
      vpx_r   <= pj_r.vx - $signed(ex_rnd[EW:NORM_BITS-1]);
      vpy_r   <= pj_r.vy - $signed(ey_rnd[EW:NORM_BITS-1]);
      npx_k_r <= npx_j_r;
      npy_k_r <= npy_j_r;
    end
  end

  // Stage l: restitution gain products.
  pass_t                  pl_r;
  logic signed [GW-1:0]   gx_r, gy_r, gz_r;
  logic signed [CW-1:0]   npx_l_r, npy_l_r;
  logic signed [GAIN_W:0] gain_s;

  assign gain_s = $signed({1'b0, gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r <= '0;
    end else if (adv) begin
      pl_r    <= pk_r;
      gx_r    <= vpx_r * gain_s;
      gy_r    <= vpy_r * gain_s;
      gz_r    <= pk_r.vz * gain_s;
      npx_l_r <= npx_k_r;
      npy_l_r <= npy_k_r;
    end
  end

  // Result register: rounding, saturation and the no-contact bypass.
  logic signed [GW:0] gx_bias, gy_bias, gz_bias, gx_rnd, gy_rnd, gz_rnd;
  res_t               out_nxt;

  always_comb begin
    gx_bias = gx_r[GW-1] ? (GW+1)'(HALF_G - 1) : (GW+1)'(HALF_G);
    gy_bias = gy_r[GW-1] ? (GW+1)'(HALF_G - 1) : (GW+1)'(HALF_G);
    gz_bias = gz_r[GW-1] ? (GW+1)'(HALF_G - 1) : (GW+1)'(HALF_G);
    gx_rnd  = gx_r + gx_bias;
    gy_rnd  = gy_r + gy_bias;
    gz_rnd  = gz_r + gz_bias;
    out_nxt.kind = pl_r.kind;
    if (pl_r.kind == KIND_NONE) begin
      out_nxt.px = pl_r.px;
      out_nxt.py = pl_r.py;
      out_nxt.vx = pl_r.vx;
      out_nxt.vy = pl_r.vy;
      out_nxt.vz = pl_r.vz;
    end else begin
      out_nxt.px = npx_l_r;
      out_nxt.py = npy_l_r;
      out_nxt.vx = sat_cw($signed(gx_rnd[GW:GAIN_BITS]));
      out_nxt.vy = sat_cw($signed(gy_rnd[GW:GAIN_BITS]));
      out_nxt.vz = sat_cw($signed(gz_rnd[GW:GAIN_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= pl_r.vld;
      out_r     <= out_nxt;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.new_pos_x   = out_r.px;
  assign out_ch.new_pos_y   = out_r.py;
  assign out_ch.new_pos_z   = cz_r;
  assign out_ch.new_vel_x   = out_r.vx;
  assign out_ch.new_vel_y   = out_r.vy;
  assign out_ch.new_vel_z   = out_r.vz;
  assign out_ch.bounce_kind = out_r.kind;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the annulus boundary reflection core with a built-in predictor.
`timescale 1ns / 100ps

module tb_top;
  import abr_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } particle_t;

  typedef struct {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    kind_t              bounce_kind;
  } bounce_t;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  abr_in_if  #(32) in_ch ();
  abr_out_if #(32) out_ch ();

  annulus_boundary_reflect_core #(.COORD_WIDTH(32)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Arena setup as the block should hold it.
  wide_t arena_cx = 0, arena_cy = 0, arena_cz = 0;
  wide_t arena_inner = RST_INNER, arena_outer = RST_OUTER, arena_gain = RST_GAIN;

  particle_t particle_q[$];
  bounce_t   bounce_q[$];
  int n_in = 0, n_out = 0, n_errors = 0, idle_cycles = 0;
  int kind_seen[3] = '{0, 0, 0};
  logic in_taken = 1'b0;

  function automatic wide_t round_shift(wide_t a, int s);
    wide_t m;
    m = (a < 0) ? -a : a;
    m = (m + (wide_t'(1) <<< (s - 1))) >>> s;
    return (a < 0) ? -m : m;
  endfunction

  function automatic wide_t round_div(wide_t n, wide_t d);
    wide_t m, q, r;
    m = (n < 0) ? -n : n;
    q = m / d;
    r = m % d;
    if (r >= d - r) q = q + 1;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic wide_t floor_sqrt(wide_t v);
    wide_t root, c;
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      c = root | (wide_t'(1) <<< b);
      if (c * c <= v) root = c;
    end
    return root;
  endfunction

  function automatic bounce_t reflect_particle(particle_t p);
    bounce_t res;
    wide_t dx, dy, r2, rad, root, nx, ny, relx, rely, d, vx, vy, vz, px, py;
    kind_t kind;
    px = wide_t'(p.pos_x);
    py = wide_t'(p.pos_y);
    vx = wide_t'(p.vel_x);
    vy = wide_t'(p.vel_y);
    vz = wide_t'(p.vel_z);
    dx = px - arena_cx;
    dy = py - arena_cy;
    r2 = dx * dx + dy * dy;
    kind = KIND_NONE;
    rad = 0;
    if (r2 > arena_outer * arena_outer) begin
      kind = KIND_OUTER;
      rad = arena_outer;
    end else if (r2 < arena_inner * arena_inner) begin
      kind = KIND_INNER;
      rad = arena_inner;
    end
    if (kind != KIND_NONE) begin
      root = floor_sqrt(r2);
      if (root == 0) begin
        nx = wide_t'(1) <<< NORM_BITS;
        ny = 0;
        relx = rad;
        rely = 0;
      end else begin
        nx = round_div(dx <<< NORM_BITS, root);
        ny = round_div(dy <<< NORM_BITS, root);
        relx = round_div(dx * rad, root);
        rely = round_div(dy * rad, root);
      end
      px = arena_cx + relx;
      py = arena_cy + rely;
      d = round_shift(vx * nx + vy * ny, NORM_BITS);
      vx = vx - round_shift(d * nx, NORM_BITS - 1);
      vy = vy - round_shift(d * ny, NORM_BITS - 1);
      vx = round_shift(vx * arena_gain, GAIN_BITS);
      vy = round_shift(vy * arena_gain, GAIN_BITS);
      vz = round_shift(vz * arena_gain, GAIN_BITS);
    end
    res.new_pos_x = clamp32(px);
    res.new_pos_y = clamp32(py);
    res.new_pos_z = clamp32(arena_cz);
    res.new_vel_x = clamp32(vx);
    res.new_vel_y = clamp32(vy);
    res.new_vel_z = clamp32(vz);
    res.bounce_kind = kind;
    return res;
  endfunction

  // Input side: bursts of random length separated by random gaps.
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_ch.valid && !in_taken)) begin
        if (in_taken) void'(particle_q.pop_front());
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (particle_q.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.pos_x <= particle_q[0].pos_x;
          in_ch.pos_y <= particle_q[0].pos_y;
          in_ch.vel_x <= particle_q[0].vel_x;
          in_ch.vel_y <= particle_q[0].vel_y;
          in_ch.vel_z <= particle_q[0].vel_z;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: rotating stall patterns plus one long hold-off that backs the pipeline up.
  int ready_cyc = 0, hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      ready_cyc++;
      if (!hold_done && n_in >= 300) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case (ready_cyc[9:8])
          2'd0: out_ch.ready <= 1'b1;
          2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ch.ready <= (ready_cyc[2:0] != 3'd0);
          default: out_ch.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // Transfers are predicted and checked at the rising edge.
  always @(posedge clk) begin
    bounce_t exp_res;
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        bounce_q.push_back(reflect_particle('{in_ch.pos_x, in_ch.pos_y, in_ch.vel_x,
                                              in_ch.vel_y, in_ch.vel_z}));
        n_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_out++;
        if (bounce_q.size() == 0) begin
          $error("Result transfer with no expectation pending");
          n_errors++;
        end else begin
          exp_res = bounce_q.pop_front();
          if (out_ch.bounce_kind <= 2) kind_seen[out_ch.bounce_kind]++;
          if (out_ch.new_pos_x !== exp_res.new_pos_x) begin
            $error("new_pos_x expected %0d got %0d", exp_res.new_pos_x, out_ch.new_pos_x);
            n_errors++;
          end
          if (out_ch.new_pos_y !== exp_res.new_pos_y) begin
            $error("new_pos_y expected %0d got %0d", exp_res.new_pos_y, out_ch.new_pos_y);
            n_errors++;
          end
          if (out_ch.new_pos_z !== exp_res.new_pos_z) begin
            $error("new_pos_z expected %0d got %0d", exp_res.new_pos_z, out_ch.new_pos_z);
            n_errors++;
          end
          if (out_ch.new_vel_x !== exp_res.new_vel_x) begin
            $error("new_vel_x expected %0d got %0d", exp_res.new_vel_x, out_ch.new_vel_x);
            n_errors++;
          end
          if (out_ch.new_vel_y !== exp_res.new_vel_y) begin
            $error("new_vel_y expected %0d got %0d", exp_res.new_vel_y, out_ch.new_vel_y);
            n_errors++;
          end
          if (out_ch.new_vel_z !== exp_res.new_vel_z) begin
            $error("new_vel_z expected %0d got %0d", exp_res.new_vel_z, out_ch.new_vel_z);
            n_errors++;
          end
          if (out_ch.bounce_kind !== exp_res.bounce_kind) begin
            $error("bounce_kind expected %0d got %0d", exp_res.bounce_kind, out_ch.bounce_kind);
            n_errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_CENTER_X: arena_cx = wide_t'($signed(value));
      REG_CENTER_Y: arena_cy = wide_t'($signed(value));
      REG_CENTER_Z: arena_cz = wide_t'($signed(value));
      REG_INNER:    arena_inner = wide_t'(value[30:0]);
      REG_OUTER:    arena_outer = wide_t'(value[30:0]);
      REG_GAIN:     arena_gain = wide_t'(value[15:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_arena(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] inner, logic [31:0] outer, logic [31:0] gain);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_INNER, inner);
    write_reg(REG_OUTER, outer);
    write_reg(REG_GAIN, gain);
  endtask

  task automatic wait_idle();
    while (particle_q.size() != 0 || bounce_q.size() != 0 || in_ch.valid) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic add_particle(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                              logic [31:0] vy, logic [31:0] vz);
    particle_q.push_back('{px, py, vx, vy, vz});
  endtask

  function automatic logic [31:0] rand_vel();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return $urandom_range(0, 1 << 20) - (1 << 19);
  endfunction

  // Random particles are mostly placed close to one of the walls, so both bounces and
  // near misses are frequent; the rest land anywhere or within the wall radius on each axis.
  task automatic add_random_particles(int count);
    wide_t rad, off, dx, dy, tmp;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      rad = ($urandom_range(0, 1) == 0) ? arena_outer : arena_inner;
      if (mode <= 5) begin
        off = wide_t'($urandom_range(0, 64)) - 32;
        dx = rad + off;
        dy = wide_t'($urandom_range(0, 2048)) - 1024;
        if ($urandom_range(0, 3) == 0) dy = rad / 2 + dy;
      end else if (mode <= 7) begin
        dx = wide_t'($signed($urandom())) - arena_cx;
        dy = wide_t'($signed($urandom())) - arena_cy;
      end else begin
        dx = wide_t'($urandom_range(0, 32'h7fffffff)) % (rad + 1);
        dy = wide_t'($urandom_range(0, 32'h7fffffff)) % (rad + 1);
      end
      if ($urandom_range(0, 1) == 0) begin
        tmp = dx;
        dx = dy;
        dy = tmp;
      end
      if ($urandom_range(0, 1) == 0) dx = -dx;
      if ($urandom_range(0, 1) == 0) dy = -dy;
      tmp = arena_cx + dx;
      off = arena_cy + dy;
      add_particle(tmp[31:0], off[31:0], rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset arena: center point, walls exactly hit and just missed, extreme fields.
    add_particle(0, 0, 32'sd1000, -32'sd500, 32'sd256);
    add_particle(128000, 0, 32'sd256, 32'sd256, 0);
    add_particle(128001, 0, 32'sd256, 32'sd256, 32'sd256);
    add_particle(0, -128001, 32'sd77, -32'sd999, -32'sd1);
    add_particle(76800, 0, 32'sd5, 32'sd5, 32'sd5);
    add_particle(76799, 0, -32'sd256, 32'sd12, 32'sd9);
    add_particle(0, 100000, 0, 0, 0);
    add_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_particle(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    add_particle(1, -1, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_particle(-90000, 90000, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
    add_random_particles(230);
    wait_idle();

    setup_arena(32'sd256000, -32'sd512000, 32'sd1280, 100 * 256, 200 * 256, 32768);
    add_particle(32'sd256000, -32'sd512000, 32'sd300, 32'sd300, 32'sd300);
    add_random_particles(240);
    wait_idle();

    // Extreme setup: corner center, zero inner wall, widest outer wall, gain above one.
    setup_arena(32'h7fffffff, 32'h80000000, 32'h80000000, 0, 32'h7fffffff, 32'hffffffff);
    add_particle(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_particle(32'h7fffffff, 32'h80000000, 32'sd1, 32'sd1, 32'sd1);
    add_particle(0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000);
    add_random_particles(200);
    wait_idle();
    setup_arena(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    add_particle(32'h80000000, 32'h7fffffff, 32'sd40, 32'sd40, 32'sd40);
    add_particle(32'h7fffffff, 32'h80000000, 32'sd40, 32'sd40, 32'sd40);
    wait_idle();

    // Crossed walls: the outer test wins.
    setup_arena($urandom(), $urandom(), $urandom(), 500 * 256, 300 * 256, 0);
    add_random_particles(240);
    wait_idle();

    for (int k = 0; k < 4; k++) begin
      setup_arena($urandom(), $urandom(), $urandom(), $urandom_range(0, 32'h7fff_ffff) >> k * 7,
                  $urandom_range(0, 32'h7fff_ffff) >> k * 7, $urandom_range(0, 65535));
      add_random_particles(60);
      wait_idle();
    end

    $display("Covered %0d particles: %0d passed, %0d outer bounces, %0d inner bounces,",
             n_in, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("over reset, extreme, crossed-wall and random arena setups with back-pressure.");
    if (n_errors == 0 && bounce_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (bounce_q.size() != 0) $error("%0d expected results never arrived", bounce_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
